### src/rba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_pkg
// Shared types, register codes and the sine table generator for the
// rotated box AABB unit.
// ----------------------------------------------------------------------------
package rba_pkg;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        logic signed [17:0] sin_q;
        logic signed [17:0] cos_q;
    } trig_t;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;
    localparam logic [2:0] REG_SCALE = 3'd6;

    localparam logic [31:0] SCALE_ONE = 32'd65536;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    // Taylor denominators (2n)(2n+1), n = 1..10
    localparam logic [63:0] SIN_DIV [10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // Quarter-wave entry k: Q30 series, rounded to Q16, clamped to 1.0.
    // Evaluated at elaboration only.
    function automatic logic [16:0] rba_sin_entry(input int unsigned k,
                                                  input int unsigned qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        int                 n;
        x    = (64'(k) * HALF_PI_Q30 + ((64'd1 << qbits) >> 1)) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 10; n++)
        begin
            term = ((term * x2) >> 30) / SIN_DIV[n-1];
            if ((n & 1) != 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        r = (sum + 64'sd8192) >>> 14;
        if (r > 64'sd65536)
            r = 64'sd65536;
        return 17'(r);
    endfunction

endpackage

### src/rba_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba channel interfaces
// Query, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rba_req_if
    import rba_pkg::*;
#(
    parameter int ANGLE_BITS = 12
);
    logic                  valid;
    logic                  ready;
    coord_t                pos_x;
    coord_t                pos_y;
    coord_t                pos_z;
    logic [ANGLE_BITS-1:0] yaw;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output yaw, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input yaw, output ready);
endinterface

interface rba_rsp_if
    import rba_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;

    modport source (output valid, output out_min_x, output out_min_y,
                    output out_min_z, output out_max_x, output out_max_y,
                    output out_max_z, input ready);
    modport sink   (input valid, input out_min_x, input out_min_y,
                    input out_min_z, input out_max_x, input out_max_y,
                    input out_max_z, output ready);
endinterface

interface rba_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/rba_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rba_sincos
// Quarter-wave sine ROM with registered reads; gives Q16 sine and cosine
// of a turn angle in the cycle after the enable.
// ----------------------------------------------------------------------------
module rba_sincos
    import rba_pkg::*;
#(
    parameter int ANGLE_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] yaw,
    output trig_t                 trig
);

    localparam int QBITS   = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam logic [QBITS:0] QUARTER_K = {1'b1, {QBITS{1'b0}}};

    logic [16:0] rom_w [QUARTER+1];

    generate
        for (genvar gi = 0; gi <= QUARTER; gi++)
        begin : g_rom
            assign rom_w[gi] = rba_sin_entry(gi, QBITS);
        end
    endgenerate

    logic [1:0]       quad_s;
    logic [1:0]       quad_c;
    logic [QBITS-1:0] frac;
    logic [QBITS:0]   k_s;
    logic [QBITS:0]   k_c;

    assign quad_s = yaw[ANGLE_BITS-1 -: 2];
    assign quad_c = quad_s + 2'd1;       // cos(a) = sin(a + quarter turn)
    assign frac   = yaw[QBITS-1:0];
    assign k_s    = quad_s[0] ? QUARTER_K - {1'b0, frac} : {1'b0, frac};
    assign k_c    = quad_c[0] ? QUARTER_K - {1'b0, frac} : {1'b0, frac};

    logic [16:0] sin_mag_reg;
    logic [16:0] cos_mag_reg;
    logic        sin_neg_reg;
    logic        cos_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= rom_w[k_s];
            cos_mag_reg <= rom_w[k_c];
            sin_neg_reg <= quad_s[1];
            cos_neg_reg <= quad_c[1];
        end
    end

    assign trig.sin_q = sin_neg_reg ? -$signed({1'b0, sin_mag_reg})
                                    : $signed({1'b0, sin_mag_reg});
    assign trig.cos_q = cos_neg_reg ? -$signed({1'b0, cos_mag_reg})
                                    : $signed({1'b0, cos_mag_reg});

endmodule

### src/rotated_box_aabb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_box_aabb_unit
// Axis-aligned bounds of a scaled, centered, yawed local box placed at a
// world position. Q16.16 coordinates, results saturated to 32 bits.
// ----------------------------------------------------------------------------
// Throughput: one query per cycle unless the result output stalls; each of the 9
//   pipeline stages holds one item and a stage refills as soon as its item moves on.
// Reset clears all stage valid bits and loads the box registers with zero
//   and the scale with 1.0; no clearing pass.
// ----------------------------------------------------------------------------
module rotated_box_aabb_unit
    import rba_pkg::*;
#(
    parameter int ANGLE_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    rba_req_if.sink   req,
    rba_rsp_if.source rsp,
    rba_cfg_if.sink   cfg
);

    localparam int NSTG = 9;

    localparam logic signed [52:0] SAT_HI = 53'sd2147483647;
    localparam logic signed [52:0] SAT_LO = -53'sd2147483648;

    function automatic coord_t sat32(input logic signed [52:0] v);
        if (v > SAT_HI)
            return coord_t'(SAT_HI);
        else if (v < SAT_LO)
            return coord_t'(SAT_LO);
        else
            return coord_t'(v);
    endfunction

    function automatic coord_t min2(input coord_t a, input coord_t b);
        return (b < a) ? b : a;
    endfunction

    function automatic coord_t max2(input coord_t a, input coord_t b);
        return (b > a) ? b : a;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    coord_t      lmin_reg [3];
    coord_t      lmax_reg [3];
    logic [31:0] scale_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmin_reg  <= '{default: '0};
            lmax_reg  <= '{default: '0};
            scale_reg <= SCALE_ONE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MIN_X: lmin_reg[0] <= cfg.data;
                REG_MIN_Y: lmin_reg[1] <= cfg.data;
                REG_MIN_Z: lmin_reg[2] <= cfg.data;
                REG_MAX_X: lmax_reg[0] <= cfg.data;
                REG_MAX_Y: lmax_reg[1] <= cfg.data;
                REG_MAX_Z: lmax_reg[2] <= cfg.data;
                REG_SCALE: scale_reg   <= cfg.data;
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !valid_reg[NSTG-1] || rsp.ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !valid_reg[i] || en[i+1];
    end

    assign valid_next = {valid_reg[NSTG-2:0], req.valid};
    assign req.ready  = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            for (int i = 0; i < NSTG; i++)
                if (en[i])
                    valid_reg[i] <= valid_next[i];
        end
    end

    // ------------------------------------------------------------------
    // S1: scale products, trig ROM read
    // index 0..2 = min x/y/z, 3..5 = max x/y/z
    // ------------------------------------------------------------------
    trig_t                 trig_w;
    logic [ANGLE_BITS-1:0] yaw_w;

    assign yaw_w = req.yaw;

    rba_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos
    (
        .clk  (clk),
        .en   (en[0]),
        .yaw  (yaw_w),
        .trig (trig_w)
    );

    logic signed [64:0] s1_prod_reg [6];
    coord_t             s1_pos_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_prod_reg[i]   <= $signed({1'b0, scale_reg}) * lmin_reg[i];
                s1_prod_reg[i+3] <= $signed({1'b0, scale_reg}) * lmax_reg[i];
            end
            s1_pos_reg[0] <= req.pos_x;
            s1_pos_reg[1] <= req.pos_y;
            s1_pos_reg[2] <= req.pos_z;
        end
    end

    // ------------------------------------------------------------------
    // S2: round scaled corners to Q16.16, center sums
    // ------------------------------------------------------------------
    logic signed [48:0] s2_sc_reg   [6];
    logic signed [32:0] s2_csum_reg [3];
    trig_t              s2_trig_reg;
    coord_t             s2_pos_reg  [3];
    logic signed [64:0] rnd_w       [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            rnd_w[i] = s1_prod_reg[i] + 65'sd32768;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 6; i++)
                s2_sc_reg[i] <= $signed(rnd_w[i][64:16]);
            for (int i = 0; i < 3; i++)
                s2_csum_reg[i] <= 33'(lmin_reg[i]) + 33'(lmax_reg[i]);
            s2_trig_reg <= trig_w;
            s2_pos_reg  <= s1_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // S3: centered value in half-LSB units: 2*scaled - (min + max)
    // ------------------------------------------------------------------
    logic signed [49:0] s3_v2_reg  [6];
    trig_t              s3_trig_reg;
    coord_t             s3_pos_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int i = 0; i < 6; i++)
                s3_v2_reg[i] <= $signed({s2_sc_reg[i], 1'b0})
                              - 50'(s2_csum_reg[i % 3]);
            s3_trig_reg <= s2_trig_reg;
            s3_pos_reg  <= s2_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // S4: split products against sin/cos, y rounding
    // j = 0,1: x min,max   j = 2,3: z min,max
    // ------------------------------------------------------------------
    logic signed [49:0] xz_w [4];

    assign xz_w[0] = s3_v2_reg[0];
    assign xz_w[1] = s3_v2_reg[3];
    assign xz_w[2] = s3_v2_reg[2];
    assign xz_w[3] = s3_v2_reg[5];

    logic signed [50:0] s4_hi_cs_reg [4];
    logic signed [35:0] s4_lo_cs_reg [4];
    logic signed [50:0] s4_hi_sn_reg [4];
    logic signed [35:0] s4_lo_sn_reg [4];
    logic signed [49:0] s4_ry_reg    [2];
    coord_t             s4_pos_reg   [3];
    logic signed [50:0] yinc_w       [2];

    assign yinc_w[0] = 51'(s3_v2_reg[1]) + 51'sd1;
    assign yinc_w[1] = 51'(s3_v2_reg[4]) + 51'sd1;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int j = 0; j < 4; j++)
            begin
                s4_hi_cs_reg[j] <= $signed(xz_w[j][49:17]) * s3_trig_reg.cos_q;
                s4_lo_cs_reg[j] <= $signed({1'b0, xz_w[j][16:0]})
                                 * s3_trig_reg.cos_q;
                s4_hi_sn_reg[j] <= $signed(xz_w[j][49:17]) * s3_trig_reg.sin_q;
                s4_lo_sn_reg[j] <= $signed({1'b0, xz_w[j][16:0]})
                                 * s3_trig_reg.sin_q;
            end
            s4_ry_reg[0] <= $signed(yinc_w[0][50:1]);
            s4_ry_reg[1] <= $signed(yinc_w[1][50:1]);
            s4_pos_reg   <= s3_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // S5: recombine high/low parts; rounding half folded into cos terms
    // ------------------------------------------------------------------
    logic signed [68:0] s5_cs_reg  [4];
    logic signed [68:0] s5_sn_reg  [4];
    logic signed [49:0] s5_ry_reg  [2];
    coord_t             s5_pos_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            for (int j = 0; j < 4; j++)
            begin
                s5_cs_reg[j] <= (69'(s4_hi_cs_reg[j]) <<< 17)
                              + 69'(s4_lo_cs_reg[j]) + 69'sd65536;
                s5_sn_reg[j] <= (69'(s4_hi_sn_reg[j]) <<< 17)
                              + 69'(s4_lo_sn_reg[j]);
            end
            s5_ry_reg  <= s4_ry_reg;
            s5_pos_reg <= s4_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // S6: rotate, floor to Q16.16; corner index = 2*x_sel + z_sel
    // ------------------------------------------------------------------
    logic signed [68:0] rx_w [4];
    logic signed [68:0] rz_w [4];

    always_comb
    begin
        for (int a = 0; a < 2; a++)
            for (int b = 0; b < 2; b++)
            begin
                rx_w[2*a+b] = s5_cs_reg[a] + s5_sn_reg[2+b];
                rz_w[2*a+b] = s5_cs_reg[2+b] - s5_sn_reg[a];
            end
    end

    logic signed [51:0] s6_rx_reg  [4];
    logic signed [51:0] s6_rz_reg  [4];
    logic signed [49:0] s6_ry_reg  [2];
    coord_t             s6_pos_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int c = 0; c < 4; c++)
            begin
                s6_rx_reg[c] <= $signed(rx_w[c][68:17]);
                s6_rz_reg[c] <= $signed(rz_w[c][68:17]);
            end
            s6_ry_reg  <= s5_ry_reg;
            s6_pos_reg <= s5_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // S7: translate and saturate
    // ------------------------------------------------------------------
    coord_t s7_px_reg [4];
    coord_t s7_pz_reg [4];
    coord_t s7_py_reg [2];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            for (int c = 0; c < 4; c++)
            begin
                s7_px_reg[c] <= sat32(53'(s6_rx_reg[c]) + 53'(s6_pos_reg[0]));
                s7_pz_reg[c] <= sat32(53'(s6_rz_reg[c]) + 53'(s6_pos_reg[2]));
            end
            for (int b = 0; b < 2; b++)
                s7_py_reg[b] <= sat32(53'(s6_ry_reg[b]) + 53'(s6_pos_reg[1]));
        end
    end

    // ------------------------------------------------------------------
    // S8: first level of the min/max tree
    // ------------------------------------------------------------------
    coord_t s8_xlo_reg [2];
    coord_t s8_xhi_reg [2];
    coord_t s8_zlo_reg [2];
    coord_t s8_zhi_reg [2];
    coord_t s8_ylo_reg;
    coord_t s8_yhi_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            for (int h = 0; h < 2; h++)
            begin
                s8_xlo_reg[h] <= min2(s7_px_reg[2*h], s7_px_reg[2*h+1]);
                s8_xhi_reg[h] <= max2(s7_px_reg[2*h], s7_px_reg[2*h+1]);
                s8_zlo_reg[h] <= min2(s7_pz_reg[2*h], s7_pz_reg[2*h+1]);
                s8_zhi_reg[h] <= max2(s7_pz_reg[2*h], s7_pz_reg[2*h+1]);
            end
            s8_ylo_reg <= min2(s7_py_reg[0], s7_py_reg[1]);
            s8_yhi_reg <= max2(s7_py_reg[0], s7_py_reg[1]);
        end
    end

    // ------------------------------------------------------------------
    // S9: output register
    // ------------------------------------------------------------------
    coord_t out_lo_reg [3];
    coord_t out_hi_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            out_lo_reg[0] <= min2(s8_xlo_reg[0], s8_xlo_reg[1]);
            out_hi_reg[0] <= max2(s8_xhi_reg[0], s8_xhi_reg[1]);
            out_lo_reg[1] <= s8_ylo_reg;
            out_hi_reg[1] <= s8_yhi_reg;
            out_lo_reg[2] <= min2(s8_zlo_reg[0], s8_zlo_reg[1]);
            out_hi_reg[2] <= max2(s8_zhi_reg[0], s8_zhi_reg[1]);
        end
    end

    assign rsp.valid     = valid_reg[NSTG-1];
    assign rsp.out_min_x = out_lo_reg[0];
    assign rsp.out_min_y = out_lo_reg[1];
    assign rsp.out_min_z = out_lo_reg[2];
    assign rsp.out_max_x = out_hi_reg[0];
    assign rsp.out_max_y = out_hi_reg[1];
    assign rsp.out_max_z = out_hi_reg[2];

endmodule
